>>> hw/rtl/battery_cycle_stats_tracker_top_macros.svh
// Assertion macros shared by the battery cycle stats checker.
`ifndef BATTERY_CYCLE_STATS_TRACKER_TOP_MACROS_SVH
`define BATTERY_CYCLE_STATS_TRACKER_TOP_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define BCST_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("bcst checker: property failed");

// Clocked check that also holds during reset.
`define BCST_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bcst checker: reset property failed");

`endif

>>> hw/rtl/bcst_pkg.sv
// Types, constants and operation codes for the battery cycle stats tracker.
package bcst_pkg;

	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned PCT_W   = 8;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned DAYS_W  = 8;

	localparam logic [OP_W-1:0] OP_UPDATE  = 2'd0;
	localparam logic [OP_W-1:0] OP_PAGE    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

	localparam logic [EPOCH_W-1:0] WEEK_SECS  = 32'd604800;
	localparam logic [EPOCH_W-1:0] PAGE_LIMIT = 32'd65535;
	localparam logic [PCT_W-1:0]   PCT_MAX    = 8'd100;

	// 86400 = 2^7 * 675; the odd part is divided by a reciprocal multiply,
	// exact for every 25-bit dividend.
	localparam int unsigned DAY_SHIFT   = 7;
	localparam int unsigned DIFF_HI_W   = EPOCH_W - DAY_SHIFT;
	localparam int unsigned RECIP_W     = 26;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam logic [RECIP_W-1:0] DAY_RECIP = 26'd50903317;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic               usb_connected;
		logic [PCT_W-1:0]   battery_pct;
		logic [EPOCH_W-1:0] now_epoch;
		logic [EPOCH_W-1:0] restore_seconds;
		logic [EPOCH_W-1:0] restore_pages;
		logic [EPOCH_W-1:0] restore_charge_start;
		logic [EPOCH_W-1:0] restore_last_end;
	} item_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] seconds_on_battery;
		logic [EPOCH_W-1:0] pages_on_battery;
		logic [EPOCH_W-1:0] cycle_start;
		logic [EPOCH_W-1:0] charge_end;
		logic [PCT_W-1:0]   level_pct;
		logic               charging;
	} snap_t;

	// Elapsed time since cycle start, pre-shifted for the day divider.
	typedef struct packed {
		logic                 ok;
		logic [DIFF_HI_W-1:0] diff_hi;
	} span_t;

endpackage

>>> hw/rtl/battery_cycle_stats_tracker_top.sv
// Top level of the battery cycle stats tracker: handshake and pipeline registers.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+------------------------------------------
//  update  | upd_valid  | upd_stall  | operation .. restore_last_end
//  snapshot| snap_valid | snap_stall | seconds_on_battery .. cycle_days
//
// One item per cycle sustained while snap_stall is low; a result passes the input
// register, the state update and the day multiply into the output register.
// State is written as an item leaves the input register, so snapshots keep order.
// A stall holds only the stages that are full; empty stages keep filling.
// Reset clears all tracker state and every stage valid bit.
module battery_cycle_stats_tracker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd_valid,
	output logic                          upd_stall,
	input  logic [bcst_pkg::OP_W-1:0]     operation,
	input  logic                          usb_connected,
	input  logic [bcst_pkg::PCT_W-1:0]    battery_pct,
	input  logic [bcst_pkg::EPOCH_W-1:0]  now_epoch,
	input  logic [bcst_pkg::EPOCH_W-1:0]  restore_seconds,
	input  logic [bcst_pkg::EPOCH_W-1:0]  restore_pages,
	input  logic [bcst_pkg::EPOCH_W-1:0]  restore_charge_start,
	input  logic [bcst_pkg::EPOCH_W-1:0]  restore_last_end,
	output logic                          snap_valid,
	input  logic                          snap_stall,
	output logic [bcst_pkg::EPOCH_W-1:0]  seconds_on_battery,
	output logic [bcst_pkg::EPOCH_W-1:0]  pages_on_battery,
	output logic [bcst_pkg::EPOCH_W-1:0]  cycle_start,
	output logic [bcst_pkg::EPOCH_W-1:0]  charge_end,
	output logic [bcst_pkg::PCT_W-1:0]    level_pct,
	output logic                          charging,
	output logic [bcst_pkg::DAYS_W-1:0]   cycle_days
);

	logic                         v_s1, v_s2, v_s3;
	logic                         en1, en2, en3;
	bcst_pkg::item_t              item_s1;
	bcst_pkg::snap_t              snap_s2, snap_s3, snap_nx;
	bcst_pkg::span_t              span_s2, span_nx;
	logic [bcst_pkg::DAYS_W-1:0]  days_s3, days_nx;

	assign en3       = !v_s3 || !snap_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign upd_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= upd_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && upd_valid) begin
			item_s1.operation            <= operation;
			item_s1.usb_connected        <= usb_connected;
			item_s1.battery_pct          <= battery_pct;
			item_s1.now_epoch            <= now_epoch;
			item_s1.restore_seconds      <= restore_seconds;
			item_s1.restore_pages        <= restore_pages;
			item_s1.restore_charge_start <= restore_charge_start;
			item_s1.restore_last_end     <= restore_last_end;
		end
		if (en2 && v_s1) begin
			snap_s2 <= snap_nx;
			span_s2 <= span_nx;
		end
		if (en3 && v_s2) begin
			snap_s3 <= snap_s2;
			days_s3 <= days_nx;
		end
	end

	bcst_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (v_s1 && en2),
		.item      (item_s1),
		.snap_next (snap_nx),
		.span_next (span_nx)
	);

	bcst_days u_days (
		.span (span_s2),
		.days (days_nx)
	);

	assign snap_valid         = v_s3;
	assign seconds_on_battery = snap_s3.seconds_on_battery;
	assign pages_on_battery   = snap_s3.pages_on_battery;
	assign cycle_start        = snap_s3.cycle_start;
	assign charge_end         = snap_s3.charge_end;
	assign level_pct          = snap_s3.level_pct;
	assign charging           = snap_s3.charging;
	assign cycle_days         = days_s3;

endmodule

>>> hw/rtl/bcst_state.sv
// Tracker state registers and the per-item update logic.
module bcst_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  bcst_pkg::item_t    item,
	output bcst_pkg::snap_t    snap_next,
	output bcst_pkg::span_t    span_next
);

	logic [bcst_pkg::EPOCH_W-1:0] secs_q, pages_q, start_q, end_q, mark_q;
	logic [bcst_pkg::PCT_W-1:0]   last_q, peak_q;
	logic                         cable_q, boot_q;

	logic [bcst_pkg::EPOCH_W-1:0] secs_n, pages_n, start_n, end_n, mark_n;
	logic [bcst_pkg::PCT_W-1:0]   last_n, peak_n;
	logic                         cable_n, boot_n;

	logic                         pct_ok, boot_a, boot_b, boot_open, late_open, add_ok;
	logic [bcst_pkg::PCT_W-1:0]   lvl, peak2;
	logic [bcst_pkg::EPOCH_W-1:0] mark2, step, diff;
	logic [bcst_pkg::EPOCH_W:0]   sum;
	logic [bcst_pkg::EPOCH_W-1:0] now;

	assign now    = item.now_epoch;
	assign pct_ok = (item.battery_pct != '0) && (item.battery_pct <= bcst_pkg::PCT_MAX);
	assign lvl    = pct_ok ? item.battery_pct : last_q;

	// boot check: second condition only matters if the first did not open a cycle
	assign boot_a    = !boot_q && (start_q == '0) && (lvl != '0);
	assign boot_b    = !boot_q && !boot_a && (peak_q != '0) && (lvl > peak_q);
	assign boot_open = boot_a || boot_b;
	assign peak2     = boot_open ? lvl : peak_q;
	assign mark2     = boot_open ? now : mark_q;

	assign late_open = !item.usb_connected
		&& (cable_q || ((peak2 != '0) && (lvl > peak2)));

	assign step   = now - mark2;
	assign sum    = {1'b0, secs_q} + {1'b0, step};
	assign add_ok = !item.usb_connected && !late_open && !boot_open
		&& (mark2 != '0) && (now > mark2) && (step < bcst_pkg::WEEK_SECS);

	always_comb begin
		secs_n  = secs_q;
		pages_n = pages_q;
		start_n = start_q;
		end_n   = end_q;
		mark_n  = mark_q;
		last_n  = last_q;
		peak_n  = peak_q;
		cable_n = cable_q;
		boot_n  = boot_q;
		case (item.operation)
			bcst_pkg::OP_UPDATE: begin
				last_n  = lvl;
				boot_n  = 1'b1;
				mark_n  = now;
				cable_n = item.usb_connected;
				peak_n  = peak2;
				if (boot_open) begin
					start_n = now;
					secs_n  = '0;
					pages_n = '0;
				end
				if (boot_b)
					end_n = now;
				if (late_open) begin
					start_n = now;
					end_n   = now;
					secs_n  = '0;
					pages_n = '0;
					peak_n  = lvl;
				end else if (item.usb_connected) begin
					if (pct_ok && (item.battery_pct > peak2))
						peak_n = item.battery_pct;
				end else if (add_ok) begin
					secs_n = sum[bcst_pkg::EPOCH_W] ? '1 : sum[bcst_pkg::EPOCH_W-1:0];
				end
			end
			bcst_pkg::OP_PAGE: begin
				if (pages_q < bcst_pkg::PAGE_LIMIT)
					pages_n = pages_q + 1'b1;
			end
			bcst_pkg::OP_RESTORE: begin
				secs_n  = item.restore_seconds;
				pages_n = item.restore_pages;
				start_n = item.restore_charge_start;
				end_n   = item.restore_last_end;
				last_n  = item.battery_pct;
				peak_n  = item.battery_pct;
				mark_n  = now;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secs_q  <= '0;
			pages_q <= '0;
			start_q <= '0;
			end_q   <= '0;
			mark_q  <= '0;
			last_q  <= '0;
			peak_q  <= '0;
			cable_q <= 1'b0;
			boot_q  <= 1'b0;
		end else if (adv) begin
			secs_q  <= secs_n;
			pages_q <= pages_n;
			start_q <= start_n;
			end_q   <= end_n;
			mark_q  <= mark_n;
			last_q  <= last_n;
			peak_q  <= peak_n;
			cable_q <= cable_n;
			boot_q  <= boot_n;
		end
	end

	assign diff = now - start_n;

	always_comb begin
		snap_next.seconds_on_battery = secs_n;
		snap_next.pages_on_battery   = pages_n;
		snap_next.cycle_start        = start_n;
		snap_next.charge_end         = end_n;
		snap_next.level_pct          = last_n;
		snap_next.charging           = cable_n;
		span_next.ok      = (start_n != '0) && (now > start_n);
		span_next.diff_hi = diff[bcst_pkg::EPOCH_W-1:bcst_pkg::DAY_SHIFT];
	end

endmodule

>>> hw/rtl/bcst_days.sv
// Whole days of a cycle: reciprocal multiply by 1/675 after the shift by 128.
module bcst_days (
	input  bcst_pkg::span_t              span,
	output logic [bcst_pkg::DAYS_W-1:0]  days
);

	logic [bcst_pkg::DIFF_HI_W+bcst_pkg::RECIP_W-1:0] prod;

	assign prod = {{bcst_pkg::RECIP_W{1'b0}}, span.diff_hi}
		* {{bcst_pkg::DIFF_HI_W{1'b0}}, bcst_pkg::DAY_RECIP};
	assign days = span.ok ? prod[bcst_pkg::RECIP_SHIFT +: bcst_pkg::DAYS_W] : '0;

endmodule

>>> hw/rtl/bcst_checker.sv
// Port-level checker for the battery cycle stats tracker, bound to the top level.
`include "battery_cycle_stats_tracker_top_macros.svh"

module bcst_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          snap_valid,
	input logic                          snap_stall,
	input logic [bcst_pkg::EPOCH_W-1:0]  seconds_on_battery,
	input logic [bcst_pkg::EPOCH_W-1:0]  pages_on_battery,
	input logic [bcst_pkg::EPOCH_W-1:0]  cycle_start,
	input logic [bcst_pkg::EPOCH_W-1:0]  charge_end,
	input logic [bcst_pkg::PCT_W-1:0]    level_pct,
	input logic                          charging,
	input logic [bcst_pkg::DAYS_W-1:0]   cycle_days
);

	logic [4*bcst_pkg::EPOCH_W+bcst_pkg::PCT_W+bcst_pkg::DAYS_W:0] snap_bus;

	assign snap_bus = {seconds_on_battery, pages_on_battery, cycle_start, charge_end,
		level_pct, charging, cycle_days};

	// a stalled snapshot stays offered
	`BCST_ASSERT(a_snap_hold, snap_valid && snap_stall |=> snap_valid)

	// and its payload does not move
	`BCST_ASSERT(a_snap_stable, snap_valid && snap_stall |=> $stable(snap_bus))

	// no open cycle means no day count
	`BCST_ASSERT(a_days_none, snap_valid && (cycle_start == '0) |-> (cycle_days == '0))

	// nothing is offered while reset is held
	`BCST_ASSERT_RST(a_reset_idle, !arst_n |-> !snap_valid)

endmodule

bind battery_cycle_stats_tracker_top bcst_checker u_bcst_checker (.*);
